FILE: rtl/event_action_rule_engine_unit_assert.svh
// Assertion macros for the rule engine
`ifndef EVENT_ACTION_RULE_ENGINE_UNIT_ASSERT_SVH
`define EVENT_ACTION_RULE_ENGINE_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge outside reset
`define EARE_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication checked in the following clock cycle
`define EARE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

FILE: rtl/eare_pkg.sv
// ----------------------------------------------------------------------------
// eare_pkg
// Types, codes and constants shared by the rule engine modules.
// ----------------------------------------------------------------------------
package eare_pkg;

    localparam int NUM_EVENTS_DEF  = 16;
    localparam int NUM_EFFECTS_DEF = 32;
    localparam int NUM_TIMERS_DEF  = 16;

    localparam logic [1:0] CMD_WR_EVENT  = 2'd0;
    localparam logic [1:0] CMD_WR_EFFECT = 2'd1;
    localparam logic [1:0] CMD_EVAL      = 2'd2;
    localparam logic [1:0] CMD_TICK      = 2'd3;

    localparam logic [2:0] EV_TRIG_RISE = 3'd0;
    localparam logic [2:0] EV_TRIG_FALL = 3'd1;
    localparam logic [2:0] EV_LOWER     = 3'd2;
    localparam logic [2:0] EV_HIGHER    = 3'd3;
    localparam logic [2:0] EV_TIMER     = 3'd4;
    localparam logic [2:0] EV_PHASE     = 3'd5;
    localparam logic [2:0] EV_BAD       = 3'd6;

    localparam logic [2:0] FX_TRIG_HIGH = 3'd0;
    localparam logic [2:0] FX_TRIG_LOW  = 3'd1;
    localparam logic [2:0] FX_SET_PARAM = 3'd2;
    localparam logic [2:0] FX_SET_TIMER = 3'd3;
    localparam logic [2:0] FX_SET_MODE  = 3'd4;
    localparam logic [2:0] FX_ON        = 3'd5;
    localparam logic [2:0] FX_OFF       = 3'd6;

    localparam logic [2:0] KIND_FREE = 3'd7;

    localparam logic [18:0] PHASE_MAX  = 19'd359999;
    localparam logic [23:0] TIMER_MAX  = 24'd9999000;
    localparam logic [18:0] PHASE_TURN = 19'd360000;

    localparam logic [1:0] TRIG_RISE = 2'b01;
    localparam logic [1:0] TRIG_FALL = 2'b11;

    localparam logic [0:0] ADDR_WAVEFORM_ON = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TICK,
        ST_EVAL,
        ST_APPLY,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_write;
        logic tick_step;
        logic eval_step;
        logic apply_step;
        logic clr_ptr;
        logic done;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic ev_last;
        logic fx_last;
        logic tm_last;
    } t_stat;

endpackage

FILE: rtl/eare_ctrl.sv
// ----------------------------------------------------------------------------
// eare_ctrl
// Sequencer that walks the event, effect and timer slots for one word.
// ----------------------------------------------------------------------------
module eare_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_cmd,
    input  eare_pkg::t_stat i_stat,
    output eare_pkg::t_ctrl o_ctrl,
    output logic           o_busy
);

    eare_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eare_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            eare_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        eare_pkg::CMD_EVAL: n_state = eare_pkg::ST_EVAL;
                        eare_pkg::CMD_TICK: n_state = eare_pkg::ST_TICK;
                        default:            n_state = eare_pkg::ST_WRITE;
                    endcase
                end
            end
            eare_pkg::ST_WRITE: n_state = eare_pkg::ST_DONE;
            eare_pkg::ST_TICK:  if (i_stat.tm_last) n_state = eare_pkg::ST_DONE;
            eare_pkg::ST_EVAL:  if (i_stat.ev_last) n_state = eare_pkg::ST_APPLY;
            eare_pkg::ST_APPLY: begin
                if (i_stat.ev_last && i_stat.fx_last) n_state = eare_pkg::ST_DONE;
            end
            eare_pkg::ST_DONE:  n_state = eare_pkg::ST_IDLE;
            default:            n_state = eare_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_busy = 1'b1;
        case (r_state)
            eare_pkg::ST_IDLE: begin
                o_busy           = 1'b0;
                o_ctrl.load_item = i_start;
                o_ctrl.clr_ptr  = 1'b1;
            end
            eare_pkg::ST_WRITE: o_ctrl.do_write = 1'b1;
            eare_pkg::ST_TICK:  o_ctrl.tick_step = 1'b1;
            eare_pkg::ST_EVAL: begin
                o_ctrl.eval_step = 1'b1;
                o_ctrl.clr_ptr   = i_stat.ev_last;
            end
            eare_pkg::ST_APPLY: o_ctrl.apply_step = 1'b1;
            eare_pkg::ST_DONE:  o_ctrl.done = 1'b1;
            default:            o_ctrl = '0;
        endcase
    end

endmodule

FILE: rtl/eare_dp.sv
// ----------------------------------------------------------------------------
// eare_dp
// Rule stores, timers, set points and the slot-serial evaluate datapath.
// ----------------------------------------------------------------------------
module eare_dp #(
    parameter int NUM_EVENTS  = eare_pkg::NUM_EVENTS_DEF,
    parameter int NUM_EFFECTS = eare_pkg::NUM_EFFECTS_DEF,
    parameter int NUM_TIMERS  = eare_pkg::NUM_TIMERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  eare_pkg::t_ctrl    i_ctrl,
    output eare_pkg::t_stat    o_stat,
    input  logic               i_waveform_on,
    input  logic [1:0]         i_cmd,
    input  logic [4:0]         i_slot,
    input  logic [3:0]         i_owner_event,
    input  logic [2:0]         i_kind,
    input  logic [3:0]         i_selector,
    input  logic [31:0]        i_rule_value,
    input  logic [31:0]        i_meas_current,
    input  logic [31:0]        i_meas_voltage,
    input  logic [31:0]        i_meas_power,
    input  logic signed [1:0]  i_trigger_in,
    input  logic [15:0]        i_wave_phase,
    output logic               o_valid,
    output logic               o_status,
    output logic [15:0]        o_fired_mask,
    output logic [31:0]        o_set_current,
    output logic [31:0]        o_set_voltage,
    output logic [31:0]        o_set_resistance,
    output logic [31:0]        o_set_power,
    output logic [1:0]         o_load_mode,
    output logic               o_load_on,
    output logic signed [1:0]  o_trigger_out
);

    localparam int EW = (NUM_EVENTS  > 1) ? $clog2(NUM_EVENTS)  : 1;
    localparam int FW = (NUM_EFFECTS > 1) ? $clog2(NUM_EFFECTS) : 1;
    localparam int TW = (NUM_TIMERS  > 1) ? $clog2(NUM_TIMERS)  : 1;

    // item registers
    logic [1:0]  r_cmd;
    logic [4:0]  r_slot;
    logic [3:0]  r_owner;
    logic [2:0]  r_kind;
    logic [3:0]  r_sel;
    logic [31:0] r_val;
    logic [31:0] r_cmp [3];
    logic [1:0]  r_trig;

    // rule stores
    logic [2:0]  r_ev_kind [NUM_EVENTS];
    logic [3:0]  r_ev_sel  [NUM_EVENTS];
    logic [31:0] r_ev_val  [NUM_EVENTS];
    logic [2:0]  r_fx_kind [NUM_EFFECTS];
    logic [3:0]  r_fx_own  [NUM_EFFECTS];
    logic [3:0]  r_fx_sel  [NUM_EFFECTS];
    logic [31:0] r_fx_val  [NUM_EFFECTS];
    logic [23:0] r_tm_cnt  [NUM_TIMERS];
    logic        r_tm_run  [NUM_TIMERS];

    logic [31:0] r_sp [4];
    logic [1:0]  r_mode;
    logic        r_on;
    logic [1:0]  r_trig_out;
    logic [18:0] r_ph_now, r_ph_before;
    logic [NUM_EVENTS-1:0] r_fired;

    logic [EW-1:0] r_ev_ptr;
    logic [FW-1:0] r_fx_ptr;
    logic [TW-1:0] r_tm_ptr;
    logic          r_status;

    logic          ev_fire;
    logic [31:0]   cmp_val;
    logic          wr_ok;
    logic [31:0]   wr_val;
    logic [34:0]   ph_prod;

    assign o_stat.ev_last = (r_ev_ptr == EW'(NUM_EVENTS - 1));
    assign o_stat.fx_last = (r_fx_ptr == FW'(NUM_EFFECTS - 1));
    assign o_stat.tm_last = (r_tm_ptr == TW'(NUM_TIMERS - 1));

    // phase in millidegrees: raw * 360000 / 65536
    assign ph_prod = 35'(i_wave_phase) * 35'(eare_pkg::PHASE_TURN);

    always_comb begin
        case (r_ev_sel[r_ev_ptr])
            4'd0:    cmp_val = r_cmp[0];
            4'd1:    cmp_val = r_cmp[1];
            4'd2:    cmp_val = r_cmp[2];
            4'd3:    cmp_val = r_sp[0];
            4'd4:    cmp_val = r_sp[1];
            4'd5:    cmp_val = r_sp[2];
            default: cmp_val = r_sp[3];
        endcase
    end

    always_comb begin
        logic [31:0] v;
        logic        sel_ok;
        logic        tm_hit;
        v      = r_ev_val[r_ev_ptr];
        sel_ok = (r_ev_sel[r_ev_ptr] < 4'd7);
        tm_hit = 1'b0;
        if (32'(r_ev_sel[r_ev_ptr]) < 32'(NUM_TIMERS)) begin
            tm_hit = r_tm_run[TW'(r_ev_sel[r_ev_ptr])]
                && (r_tm_cnt[TW'(r_ev_sel[r_ev_ptr])] == '0);
        end
        case (r_ev_kind[r_ev_ptr])
            eare_pkg::EV_TRIG_RISE: ev_fire = (r_trig == eare_pkg::TRIG_RISE);
            eare_pkg::EV_TRIG_FALL: ev_fire = (r_trig == eare_pkg::TRIG_FALL);
            eare_pkg::EV_LOWER:     ev_fire = sel_ok && (cmp_val < v);
            eare_pkg::EV_HIGHER:    ev_fire = sel_ok && (cmp_val > v);
            eare_pkg::EV_TIMER:     ev_fire = tm_hit;
            eare_pkg::EV_PHASE: begin
                if (!i_waveform_on) begin
                    ev_fire = 1'b0;
                end else if (r_ph_now >= r_ph_before) begin
                    ev_fire = (v <= 32'(r_ph_now)) && (v > 32'(r_ph_before));
                end else begin
                    ev_fire = (v > 32'(r_ph_before)) || (v <= 32'(r_ph_now));
                end
            end
            default:                ev_fire = 1'b0;
        endcase
    end

    always_comb begin
        wr_ok  = 1'b1;
        wr_val = r_val;
        if (r_cmd == eare_pkg::CMD_WR_EVENT) begin
            if (32'(r_slot) >= 32'(NUM_EVENTS) || r_kind == eare_pkg::EV_BAD) wr_ok = 1'b0;
            if ((r_kind == eare_pkg::EV_LOWER || r_kind == eare_pkg::EV_HIGHER)
                && r_sel > 4'd6) wr_ok = 1'b0;
            if (r_kind == eare_pkg::EV_TIMER && 32'(r_sel) >= 32'(NUM_TIMERS)) wr_ok = 1'b0;
            if (r_kind == eare_pkg::EV_PHASE && r_val > 32'(eare_pkg::PHASE_MAX)) begin
                wr_val = 32'(eare_pkg::PHASE_MAX);
            end
        end else begin
            if (32'(r_slot) >= 32'(NUM_EFFECTS)) wr_ok = 1'b0;
            if (r_kind != eare_pkg::KIND_FREE) begin
                if (32'(r_owner) >= 32'(NUM_EVENTS)) wr_ok = 1'b0;
                if ((r_kind == eare_pkg::FX_SET_PARAM || r_kind == eare_pkg::FX_SET_MODE)
                    && r_sel > 4'd3) wr_ok = 1'b0;
                if (r_kind == eare_pkg::FX_SET_TIMER && 32'(r_sel) >= 32'(NUM_TIMERS)) begin
                    wr_ok = 1'b0;
                end
                if (r_kind == eare_pkg::FX_SET_TIMER && r_val > 32'(eare_pkg::TIMER_MAX)) begin
                    wr_val = 32'(eare_pkg::TIMER_MAX);
                end
            end
        end
    end

    // item capture and pointers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_item) begin
            r_cmd   <= i_cmd;
            r_slot  <= i_slot;
            r_owner <= i_owner_event;
            r_kind  <= i_kind;
            r_sel   <= i_selector;
            r_val   <= i_rule_value;
            r_cmp[0] <= i_meas_current;
            r_cmp[1] <= i_meas_voltage;
            r_cmp[2] <= i_meas_power;
            r_trig  <= i_trigger_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_ptr <= '0;
            r_fx_ptr <= '0;
            r_tm_ptr <= '0;
        end else if (i_ctrl.clr_ptr) begin
            r_ev_ptr <= '0;
            r_fx_ptr <= '0;
            r_tm_ptr <= '0;
        end else begin
            if (i_ctrl.eval_step) r_ev_ptr <= r_ev_ptr + 1'b1;
            if (i_ctrl.tick_step) r_tm_ptr <= r_tm_ptr + 1'b1;
            if (i_ctrl.apply_step) begin
                if (o_stat.fx_last) begin
                    r_fx_ptr <= '0;
                    r_ev_ptr <= r_ev_ptr + 1'b1;
                end else begin
                    r_fx_ptr <= r_fx_ptr + 1'b1;
                end
            end
        end
    end

    // rule stores, timers and load state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_EVENTS; i++) begin
                r_ev_kind[i] <= eare_pkg::KIND_FREE;
                r_ev_sel[i]  <= '0;
                r_ev_val[i]  <= '0;
            end
            for (int i = 0; i < NUM_EFFECTS; i++) begin
                r_fx_kind[i] <= eare_pkg::KIND_FREE;
                r_fx_own[i]  <= '0;
                r_fx_sel[i]  <= '0;
                r_fx_val[i]  <= '0;
            end
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_tm_cnt[i] <= '0;
                r_tm_run[i] <= 1'b0;
            end
            for (int i = 0; i < 4; i++) r_sp[i] <= '0;
            r_mode      <= '0;
            r_on        <= 1'b0;
            r_trig_out  <= '0;
            r_ph_now    <= '0;
            r_ph_before <= '0;
            r_fired     <= '0;
            r_status    <= 1'b0;
        end else begin
            if (i_ctrl.load_item) begin
                r_status <= 1'b0;
                r_fired  <= '0;
                if (i_cmd == eare_pkg::CMD_EVAL) begin
                    r_ph_before <= r_ph_now;
                    r_ph_now    <= ph_prod[34:16];
                end
            end
            if (i_ctrl.do_write) begin
                r_status <= !wr_ok;
                if (wr_ok && r_cmd == eare_pkg::CMD_WR_EVENT) begin
                    r_ev_kind[EW'(r_slot)] <= r_kind;
                    r_ev_sel[EW'(r_slot)]  <= r_sel;
                    r_ev_val[EW'(r_slot)]  <= wr_val;
                end
                if (wr_ok && r_cmd == eare_pkg::CMD_WR_EFFECT) begin
                    r_fx_kind[FW'(r_slot)] <= r_kind;
                    r_fx_own[FW'(r_slot)]  <= r_owner;
                    r_fx_sel[FW'(r_slot)]  <= r_sel;
                    r_fx_val[FW'(r_slot)]  <= wr_val;
                end
            end
            if (i_ctrl.tick_step && r_tm_run[r_tm_ptr]) begin
                if (r_tm_cnt[r_tm_ptr] == '0) r_tm_run[r_tm_ptr] <= 1'b0;
                else r_tm_cnt[r_tm_ptr] <= r_tm_cnt[r_tm_ptr] - 1'b1;
            end
            if (i_ctrl.eval_step) r_fired[r_ev_ptr] <= ev_fire;
            if (i_ctrl.apply_step && r_fired[r_ev_ptr]
                && r_fx_kind[r_fx_ptr] != eare_pkg::KIND_FREE
                && 32'(r_fx_own[r_fx_ptr]) == 32'(r_ev_ptr)) begin
                case (r_fx_kind[r_fx_ptr])
                    eare_pkg::FX_TRIG_HIGH: r_trig_out <= eare_pkg::TRIG_RISE;
                    eare_pkg::FX_TRIG_LOW:  r_trig_out <= eare_pkg::TRIG_FALL;
                    eare_pkg::FX_SET_PARAM: r_sp[r_fx_sel[r_fx_ptr][1:0]] <= r_fx_val[r_fx_ptr];
                    eare_pkg::FX_SET_TIMER: begin
                        if (32'(r_fx_sel[r_fx_ptr]) < 32'(NUM_TIMERS)) begin
                            r_tm_cnt[TW'(r_fx_sel[r_fx_ptr])] <= r_fx_val[r_fx_ptr][23:0];
                            r_tm_run[TW'(r_fx_sel[r_fx_ptr])] <= 1'b1;
                        end
                    end
                    eare_pkg::FX_SET_MODE:  r_mode <= r_fx_sel[r_fx_ptr][1:0];
                    eare_pkg::FX_ON:        r_on <= 1'b1;
                    eare_pkg::FX_OFF:       r_on <= 1'b0;
                    default:                r_on <= r_on;
                endcase
            end
        end
    end

    always_comb begin
        o_fired_mask = '0;
        for (int i = 0; i < NUM_EVENTS && i < 16; i++) o_fired_mask[i] = r_fired[i];
    end

    assign o_valid          = i_ctrl.done;
    assign o_status         = r_status;
    assign o_set_current    = r_sp[0];
    assign o_set_voltage    = r_sp[1];
    assign o_set_resistance = r_sp[2];
    assign o_set_power      = r_sp[3];
    assign o_load_mode      = r_mode;
    assign o_load_on        = r_on;
    assign o_trigger_out    = r_trig_out;

endmodule

FILE: rtl/event_action_rule_engine_unit.sv
// ----------------------------------------------------------------------------
// event_action_rule_engine_unit
// Programmable event and effect rule engine for an electronic load.
// ----------------------------------------------------------------------------
// Usage: pulse start with a command word while busy is low; the word is
// taken at that edge and busy rises at once. One result word appears on
// the o_ ports for one cycle, marked by o_done, and the receiver must take
// it then; it cannot stall.
// Write commands pass through a write step, tick walks every timer slot
// and evaluate walks every event slot, then every event/effect pair. The
// slot walk tests one event slot per cycle and applies one event/effect
// pair per cycle. A new word may start in the cycle after o_done.
// The APB port holds the waveform_on bit at address 0; write it only while
// the engine is idle.
// Reset (synchronous, active low) frees all rules, stops all timers and
// clears set points, mode, load switch, trigger output and phase history.
// ----------------------------------------------------------------------------
`include "event_action_rule_engine_unit_assert.svh"

module event_action_rule_engine_unit #(
    parameter int NUM_EVENTS  = eare_pkg::NUM_EVENTS_DEF,
    parameter int NUM_EFFECTS = eare_pkg::NUM_EFFECTS_DEF,
    parameter int NUM_TIMERS  = eare_pkg::NUM_TIMERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [0:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic [4:0]        i_slot,
    input  logic [3:0]        i_owner_event,
    input  logic [2:0]        i_kind,
    input  logic [3:0]        i_selector,
    input  logic [31:0]       i_rule_value,
    input  logic [31:0]       i_meas_current,
    input  logic [31:0]       i_meas_voltage,
    input  logic [31:0]       i_meas_power,
    input  logic signed [1:0] i_trigger_in,
    input  logic [15:0]       i_wave_phase,
    output logic              o_done,
    output logic              o_status,
    output logic [15:0]       o_fired_mask,
    output logic [31:0]       o_set_current,
    output logic [31:0]       o_set_voltage,
    output logic [31:0]       o_set_resistance,
    output logic [31:0]       o_set_power,
    output logic [1:0]        o_load_mode,
    output logic              o_load_on,
    output logic signed [1:0] o_trigger_out
);

    eare_pkg::t_ctrl ctrl;
    eare_pkg::t_stat stat;
    logic            r_waveform_on;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform_on <= 1'b0;
        end else if (psel && penable && pwrite && paddr == eare_pkg::ADDR_WAVEFORM_ON) begin
            r_waveform_on <= pwdata[0];
        end
    end

    assign prdata = (paddr == eare_pkg::ADDR_WAVEFORM_ON) ? {31'd0, r_waveform_on} : '0;

    eare_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    eare_dp #(
        .NUM_EVENTS  (NUM_EVENTS),
        .NUM_EFFECTS (NUM_EFFECTS),
        .NUM_TIMERS  (NUM_TIMERS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_waveform_on    (r_waveform_on),
        .i_cmd            (i_cmd),
        .i_slot           (i_slot),
        .i_owner_event    (i_owner_event),
        .i_kind           (i_kind),
        .i_selector       (i_selector),
        .i_rule_value     (i_rule_value),
        .i_meas_current   (i_meas_current),
        .i_meas_voltage   (i_meas_voltage),
        .i_meas_power     (i_meas_power),
        .i_trigger_in     (i_trigger_in),
        .i_wave_phase     (i_wave_phase),
        .o_valid          (o_done),
        .o_status         (o_status),
        .o_fired_mask     (o_fired_mask),
        .o_set_current    (o_set_current),
        .o_set_voltage    (o_set_voltage),
        .o_set_resistance (o_set_resistance),
        .o_set_power      (o_set_power),
        .o_load_mode      (o_load_mode),
        .o_load_on        (o_load_on),
        .o_trigger_out    (o_trigger_out)
    );

    `EARE_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "busy did not rise")
    `EARE_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, busy, "result while idle")
    `EARE_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy && !o_done, "no return to idle")
    `EARE_ASSERT_IMP(a_trig_code, i_clk, i_rst_n, 1'b1, o_trigger_out != 2'b10, "bad trigger code")

endmodule
